// File: rtl/modbus_response_checker_macros.svh
// Assertion helpers shared by the checker RTL.
// Both expect clk and arst_n in scope.
`ifndef MODBUS_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RESPONSE_CHECKER_MACROS_SVH

// Same-cycle implication.
`define MBRC_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MBRC_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mbrc_pkg.sv
package mbrc_pkg;

	localparam int MAX_FRAME_BYTES = 32;
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int FRAME_LEN       = 19;
	localparam int CRC_SPAN        = 17;
	localparam int PAYLOAD_FIRST   = 3;
	localparam int PAY_DEPTH       = 14;
	localparam int PAY_IDX_W       = $clog2(PAY_DEPTH);

	localparam logic [7:0]  BYTE_COUNT_FIELD = 8'h0E;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;

	localparam logic [7:0] RST_EXP_ADDR = 8'h01;
	localparam logic [7:0] RST_EXP_FUNC = 8'h03;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_FUNC = 2'd1;

	// Request opcodes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOF  = 1'b1;

	// Verdict codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_CRC   = 2'd3;

	typedef struct packed {
		logic       opcode;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  received_bytes;
		logic [15:0] flow_value;
		logic [15:0] battery_value;
		logic [15:0] solar_value;
		logic [31:0] peak_energy;
		logic [31:0] offpeak_energy;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
	} res_t;

	typedef struct packed {
		logic [7:0] exp_addr;
		logic [7:0] exp_func;
	} cfg_t;

	// One byte of the reflected CRC-16, bit at a time.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/modbus_response_checker.sv
// The result of a taken end-of-frame request is registered in the output or skid slot.
// One request per cycle unless stalled; data bytes give no result, each marker gives one.
// req_stall rises only when the output slot and the skid slot both hold unread results.
// Reset: byte count 0, CRC 0xFFFF, header flag clear, expected address 1, function 3,
// result buffer empty.
module modbus_response_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mbrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                         cfg_wdata,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  mbrc_pkg::req_t                     req_data,
	output logic                               res_valid,
	input  logic                               res_stall,
	output mbrc_pkg::res_t                     res_data
);

	mbrc_pkg::cfg_t cfg_q;
	logic           accept;
	logic           push;
	logic           full;
	mbrc_pkg::res_t verdict;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.exp_addr <= mbrc_pkg::RST_EXP_ADDR;
			cfg_q.exp_func <= mbrc_pkg::RST_EXP_FUNC;
		end else if (cfg_we) begin
			case (cfg_index)
				mbrc_pkg::CFG_EXP_ADDR: cfg_q.exp_addr <= cfg_wdata;
				mbrc_pkg::CFG_EXP_FUNC: cfg_q.exp_func <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Hold requests off only while both result slots are occupied; the skid
	// slot absorbs a marker taken in the same cycle the output is stalled.
	assign req_stall = full;
	assign accept    = req_valid && !req_stall;

	// Frame state, running CRC and verdict logic.
	mbrc_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.req     (req_data),
		.cfg     (cfg_q),
		.push    (push),
		.verdict (verdict)
	);

	// Result register plus skid slot.
	mbrc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (verdict),
		.full      (full),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// File: rtl/mbrc_frame.sv
`include "modbus_response_checker_macros.svh"

module mbrc_frame (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  mbrc_pkg::req_t req,
	input  mbrc_pkg::cfg_t cfg,
	output logic          push,
	output mbrc_pkg::res_t verdict
);

	logic [mbrc_pkg::CNT_W-1:0] cnt_q;
	logic [15:0]                crc_q;
	logic                       hdr_bad_q;
	logic [15:0]                crc_frame_q;
	logic [7:0]                 pay_q [mbrc_pkg::PAY_DEPTH];

	logic                           take_byte;
	logic [mbrc_pkg::PAY_IDX_W-1:0] pay_idx;
	logic                           hdr_miss;

	assign take_byte = accept && (req.opcode == mbrc_pkg::OP_DATA)
		&& (cnt_q < mbrc_pkg::CNT_W'(mbrc_pkg::MAX_FRAME_BYTES));
	assign push    = accept && (req.opcode == mbrc_pkg::OP_EOF);
	assign pay_idx = mbrc_pkg::PAY_IDX_W'(cnt_q - mbrc_pkg::CNT_W'(mbrc_pkg::PAYLOAD_FIRST));

	always_comb begin
		hdr_miss = 1'b0;
		if (cnt_q == mbrc_pkg::CNT_W'(0) && req.rx_byte != cfg.exp_addr) begin
			hdr_miss = 1'b1;
		end
		if (cnt_q == mbrc_pkg::CNT_W'(1) && req.rx_byte != cfg.exp_func) begin
			hdr_miss = 1'b1;
		end
		if (cnt_q == mbrc_pkg::CNT_W'(2) && req.rx_byte != mbrc_pkg::BYTE_COUNT_FIELD) begin
			hdr_miss = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			crc_q     <= mbrc_pkg::CRC_INIT;
			hdr_bad_q <= 1'b0;
		end else if (push) begin
			cnt_q     <= '0;
			crc_q     <= mbrc_pkg::CRC_INIT;
			hdr_bad_q <= 1'b0;
		end else if (take_byte) begin
			cnt_q <= cnt_q + mbrc_pkg::CNT_W'(1);
			if (cnt_q < mbrc_pkg::CNT_W'(mbrc_pkg::CRC_SPAN)) begin
				crc_q <= mbrc_pkg::crc_byte(crc_q, req.rx_byte);
			end
			if (hdr_miss) begin
				hdr_bad_q <= 1'b1;
			end
		end
	end

	// Payload and frame CRC are read only once all 19 bytes are in.
	always_ff @(posedge clk) begin
		if (take_byte) begin
			if (cnt_q >= mbrc_pkg::CNT_W'(mbrc_pkg::PAYLOAD_FIRST)
				&& cnt_q < mbrc_pkg::CNT_W'(mbrc_pkg::CRC_SPAN)) begin
				pay_q[pay_idx] <= req.rx_byte;
			end
			if (cnt_q == mbrc_pkg::CNT_W'(mbrc_pkg::CRC_SPAN)) begin
				crc_frame_q[7:0] <= req.rx_byte;
			end
			if (cnt_q == mbrc_pkg::CNT_W'(mbrc_pkg::CRC_SPAN + 1)) begin
				crc_frame_q[15:8] <= req.rx_byte;
			end
		end
	end

	always_comb begin
		verdict = '0;
		verdict.received_bytes = 6'(cnt_q);
		if (cnt_q < mbrc_pkg::CNT_W'(mbrc_pkg::FRAME_LEN)) begin
			verdict.status = mbrc_pkg::ST_SHORT;
		end else if (hdr_bad_q) begin
			verdict.status = mbrc_pkg::ST_BAD;
		end else begin
			verdict.received_crc = crc_frame_q;
			verdict.computed_crc = crc_q;
			if (crc_frame_q != crc_q) begin
				verdict.status = mbrc_pkg::ST_CRC;
			end else begin
				verdict.status         = mbrc_pkg::ST_OK;
				verdict.flow_value     = {pay_q[0], pay_q[1]};
				verdict.battery_value  = {pay_q[2], pay_q[3]};
				verdict.solar_value    = {pay_q[4], pay_q[5]};
				verdict.peak_energy    = {pay_q[6], pay_q[7], pay_q[8], pay_q[9]};
				verdict.offpeak_energy = {pay_q[10], pay_q[11], pay_q[12], pay_q[13]};
			end
		end
	end

	`MBRC_CHECK(a_cnt_bounded, 1'b1, cnt_q <= mbrc_pkg::CNT_W'(mbrc_pkg::MAX_FRAME_BYTES), "byte count past frame limit")
	`MBRC_CHECK(a_ok_needs_full_frame, push && verdict.status == mbrc_pkg::ST_OK, cnt_q >= mbrc_pkg::CNT_W'(mbrc_pkg::FRAME_LEN), "ok verdict on short frame")

endmodule

// File: rtl/mbrc_outq.sv
`include "modbus_response_checker_macros.svh"

module mbrc_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mbrc_pkg::res_t push_data,
	output logic           full,
	output logic           res_valid,
	input  logic           res_stall,
	output mbrc_pkg::res_t res_data
);

	logic           out_valid_q;
	mbrc_pkg::res_t out_q;
	logic           skid_valid_q;
	mbrc_pkg::res_t skid_q;
	logic           pop;

	assign pop       = out_valid_q && !res_stall;
	assign full      = skid_valid_q;
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	`MBRC_CHECK(a_skid_behind_out, skid_valid_q, out_valid_q, "skid slot filled ahead of output")
	`MBRC_CHECK_NEXT(a_stalled_kept, out_valid_q && res_stall, out_valid_q, "stalled result dropped")

endmodule

// File: dv/tb_modbus_response_checker.sv
module tb_modbus_response_checker;
	import mbrc_pkg::*;

	// Run bound: far above the slowest legal run (about 1000 requests, each
	// with geometric sender gaps and a 50% output stall, plus one long hold-off).
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;
	localparam int HOLD_OFF_LEN = 300;

	// Register indexes that decode to nothing; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// Payload fill patterns for frame construction.
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZERO   = 1;
	localparam int FILL_ONES   = 2;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;

	modbus_response_checker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// Own copy of the checker: frame state and the two registers.
	int          m_count;
	logic [15:0] m_crc;
	bit          m_hdr_bad;
	logic [7:0]  m_pay [PAY_DEPTH];
	logic [15:0] m_frame_crc;
	logic [7:0]  m_exp_addr = RST_EXP_ADDR;
	logic [7:0]  m_exp_func = RST_EXP_FUNC;

	// Verdicts predicted but not yet seen on the output, oldest first.
	res_t pending_verdicts[$];

	// Frame under construction by the stimulus tasks.
	logic [7:0] frame_bytes[$];

	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_off_cycles = 0;
	int hold_off_seq = 0;

	int cycle_count = 0;
	int fail_count = 0;
	int verdicts_checked = 0;
	int frames_sent = 0;
	int items_sent = 0;
	int status_seen [4];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// One byte of the reflected CRC-16, shifting out the low bit each step.
	function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
		c = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = {1'b0, c[15:1]} ^ CRC_POLY;
			end else begin
				c = {1'b0, c[15:1]};
			end
		end
		return c;
	endfunction

	function void clear_frame_model();
		m_count = 0;
		m_crc = CRC_INIT;
		m_hdr_bad = 1'b0;
		foreach (m_pay[i]) m_pay[i] = 8'h00;
		m_frame_crc = 16'h0000;
	endfunction

	// Advance the frame model by one accepted request; a marker queues a verdict.
	function void advance_frame_model(input req_t r);
		res_t v;
		v = '0;
		if (r.opcode == OP_DATA) begin
			// Saturated frame: drop the byte entirely.
			if (m_count >= MAX_FRAME_BYTES) return;
			if (m_count < CRC_SPAN) m_crc = crc16_step(m_crc, r.rx_byte);
			if (m_count == 0 && r.rx_byte != m_exp_addr) m_hdr_bad = 1'b1;
			if (m_count == 1 && r.rx_byte != m_exp_func) m_hdr_bad = 1'b1;
			if (m_count == 2 && r.rx_byte != BYTE_COUNT_FIELD) m_hdr_bad = 1'b1;
			if (m_count >= PAYLOAD_FIRST && m_count < PAYLOAD_FIRST + PAY_DEPTH)
				m_pay[m_count - PAYLOAD_FIRST] = r.rx_byte;
			if (m_count == CRC_SPAN) m_frame_crc[7:0] = r.rx_byte;
			if (m_count == CRC_SPAN + 1) m_frame_crc[15:8] = r.rx_byte;
			m_count++;
			return;
		end
		v.received_bytes = 6'(m_count);
		if (m_count < FRAME_LEN) begin
			v.status = ST_SHORT;
		end else if (m_hdr_bad) begin
			v.status = ST_BAD;
		end else begin
			v.received_crc = m_frame_crc;
			v.computed_crc = m_crc;
			if (m_frame_crc != m_crc) begin
				v.status = ST_CRC;
			end else begin
				v.status = ST_OK;
				v.flow_value = {m_pay[0], m_pay[1]};
				v.battery_value = {m_pay[2], m_pay[3]};
				v.solar_value = {m_pay[4], m_pay[5]};
				v.peak_energy = {m_pay[6], m_pay[7], m_pay[8], m_pay[9]};
				v.offpeak_energy = {m_pay[10], m_pay[11], m_pay[12], m_pay[13]};
			end
		end
		pending_verdicts.push_back(v);
		clear_frame_model();
	endfunction

	// Offer one request after a random idle gap; return once it is taken.
	task automatic send_req(input logic op, input logic [7:0] b);
		req_t r;
		r.opcode = op;
		r.rx_byte = b;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		advance_frame_model(r);
		items_sent++;
	endtask

	// Send the frame under construction, then its end-of-frame marker.
	task automatic send_frame();
		foreach (frame_bytes[i]) send_req(OP_DATA, frame_bytes[i]);
		send_req(OP_EOF, 8'($urandom_range(255)));
		frames_sent++;
	endtask

	// Build a full 19-byte response with a correct CRC for the given header.
	task automatic build_frame(input logic [7:0] addr, input logic [7:0] func,
			input logic [7:0] cnt, input int fill);
		logic [15:0] c;
		frame_bytes = {};
		frame_bytes.push_back(addr);
		frame_bytes.push_back(func);
		frame_bytes.push_back(cnt);
		repeat (PAY_DEPTH) begin
			if (fill == FILL_ZERO) begin
				frame_bytes.push_back(8'h00);
			end else if (fill == FILL_ONES) begin
				frame_bytes.push_back(8'hFF);
			end else begin
				frame_bytes.push_back(8'($urandom_range(255)));
			end
		end
		c = CRC_INIT;
		for (int i = 0; i < CRC_SPAN; i++) c = crc16_step(c, frame_bytes[i]);
		frame_bytes.push_back(c[7:0]);
		frame_bytes.push_back(c[15:8]);
	endtask

	task automatic append_random_bytes(input int n);
		repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
	endtask

	// Drop valid, wait for every verdict to come out, then let the pipe settle.
	task automatic wait_until_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_EXP_ADDR) m_exp_addr = val;
		if (idx == CFG_EXP_FUNC) m_exp_func = val;
		@(posedge clk);
	endtask

	// Reset registers, empty marker and clean frames at the payload extremes.
	task automatic test_reset_defaults();
		send_req(OP_EOF, 8'h00);
		build_frame(RST_EXP_ADDR, RST_EXP_FUNC, BYTE_COUNT_FIELD, FILL_ZERO);
		send_frame();
		build_frame(RST_EXP_ADDR, RST_EXP_FUNC, BYTE_COUNT_FIELD, FILL_ONES);
		foreach (frame_bytes[i]) send_req(OP_DATA, frame_bytes[i]);
		send_req(OP_EOF, 8'hFF);
		frames_sent++;
		wait_until_idle();
	endtask

	// Every verdict, the verdict priority, long and saturated frames.
	task automatic test_verdict_cases();
		// short by one byte
		build_frame(m_exp_addr, m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
		void'(frame_bytes.pop_back());
		send_frame();
		// each header byte wrong on its own
		build_frame(m_exp_addr ^ 8'h80, m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
		send_frame();
		build_frame(m_exp_addr, m_exp_func ^ 8'h01, BYTE_COUNT_FIELD, FILL_RANDOM);
		send_frame();
		build_frame(m_exp_addr, m_exp_func, 8'h0F, FILL_RANDOM);
		send_frame();
		// CRC broken in the received field, then in the covered span
		build_frame(m_exp_addr, m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
		frame_bytes[CRC_SPAN] ^= 8'h01;
		send_frame();
		build_frame(m_exp_addr, m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
		frame_bytes[9] ^= 8'h40;
		send_frame();
		// short wins over a bad header
		build_frame(8'h00 ^ m_exp_addr ^ 8'hFF, m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
		repeat (5) void'(frame_bytes.pop_back());
		send_frame();
		// bad header wins over a bad CRC
		build_frame(m_exp_addr, 8'hFF ^ m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
		frame_bytes[CRC_SPAN + 1] ^= 8'h80;
		send_frame();
		// trailing bytes are counted but ignored
		build_frame(m_exp_addr, m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
		append_random_bytes(6);
		send_frame();
		// exactly full, then well past the buffer size
		build_frame(m_exp_addr, m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
		append_random_bytes(MAX_FRAME_BYTES - FRAME_LEN);
		send_frame();
		build_frame(m_exp_addr, m_exp_func, BYTE_COUNT_FIELD, FILL_ONES);
		append_random_bytes(MAX_FRAME_BYTES);
		send_frame();
		wait_until_idle();
	endtask

	// Register extremes, dropped writes to spare indexes, change inside a frame.
	task automatic test_register_settings();
		cfg_write(CFG_EXP_ADDR, 8'h00);
		cfg_write(CFG_EXP_FUNC, 8'hFF);
		build_frame(8'h00, 8'hFF, BYTE_COUNT_FIELD, FILL_RANDOM);
		send_frame();
		build_frame(RST_EXP_ADDR, RST_EXP_FUNC, BYTE_COUNT_FIELD, FILL_RANDOM);
		send_frame();
		wait_until_idle();

		cfg_write(CFG_EXP_ADDR, 8'hFF);
		cfg_write(CFG_EXP_FUNC, 8'h00);
		cfg_write(CFG_SPARE_A, 8'h5A);
		cfg_write(CFG_SPARE_B, 8'hA5);
		build_frame(8'hFF, 8'h00, BYTE_COUNT_FIELD, FILL_RANDOM);
		send_frame();
		wait_until_idle();

		// Byte 0 is judged against the old address, byte 1 against the new function.
		build_frame(8'hFF, 8'h42, BYTE_COUNT_FIELD, FILL_RANDOM);
		send_req(OP_DATA, frame_bytes[0]);
		wait_until_idle();
		cfg_write(CFG_EXP_ADDR, 8'h11);
		cfg_write(CFG_EXP_FUNC, 8'h42);
		for (int i = 1; i < frame_bytes.size(); i++) send_req(OP_DATA, frame_bytes[i]);
		send_req(OP_EOF, 8'($urandom_range(255)));
		frames_sent++;
		wait_until_idle();

		cfg_write(CFG_EXP_ADDR, RST_EXP_ADDR);
		cfg_write(CFG_EXP_FUNC, RST_EXP_FUNC);
	endtask

	// Hold the output off for a long stretch while markers keep coming, so the
	// result buffer fills and the input stalls; then release and drain.
	task automatic test_input_backpressure();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_cycles = HOLD_OFF_LEN;
		hold_off_seq++;
		build_frame(m_exp_addr, m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
		send_frame();
		repeat (20) send_req(OP_EOF, 8'($urandom_range(255)));
		build_frame(m_exp_addr, m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
		send_frame();
		wait_until_idle();
	endtask

	// Mostly well-formed frames with random content; the rest corrupted,
	// truncated, overlong or plain noise.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input logic [7:0] addr, input logic [7:0] func, input int n_frames);
		int kind;
		int idx;
		cfg_write(CFG_EXP_ADDR, addr);
		cfg_write(CFG_EXP_FUNC, func);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (n_frames) begin
			kind = $urandom_range(99);
			build_frame(m_exp_addr, m_exp_func, BYTE_COUNT_FIELD, FILL_RANDOM);
			if (kind < 65) begin
				if ($urandom_range(9) == 0) begin
					append_random_bytes($urandom_range(1, 20));
				end else begin
					append_random_bytes($urandom_range(0, 2));
				end
			end else if (kind < 77) begin
				idx = $urandom_range(0, FRAME_LEN - 1);
				frame_bytes[idx] ^= 8'(1 << $urandom_range(7));
			end else if (kind < 87) begin
				idx = $urandom_range(0, 2);
				frame_bytes[idx] ^= 8'($urandom_range(1, 255));
			end else if (kind < 95) begin
				idx = $urandom_range(0, FRAME_LEN - 1);
				while (frame_bytes.size() > idx) void'(frame_bytes.pop_back());
			end else begin
				frame_bytes = {};
				append_random_bytes($urandom_range(0, 40));
			end
			send_frame();
		end
		wait_until_idle();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
	endtask

	// Output side: check each taken verdict against the oldest prediction.
	always @(posedge clk) begin : verdict_monitor
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_verdicts.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("[%0t] verdict with nothing pending: st=%0d n=%0d",
						$time, res_data.status, res_data.received_bytes);
			end else begin
				want = pending_verdicts.pop_front();
				verdicts_checked++;
				status_seen[res_data.status]++;
				if (res_data.status !== want.status ||
						res_data.received_bytes !== want.received_bytes ||
						res_data.flow_value !== want.flow_value ||
						res_data.battery_value !== want.battery_value ||
						res_data.solar_value !== want.solar_value ||
						res_data.peak_energy !== want.peak_energy ||
						res_data.offpeak_energy !== want.offpeak_energy ||
						res_data.received_crc !== want.received_crc ||
						res_data.computed_crc !== want.computed_crc) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("[%0t] verdict %0d mismatch", $time, verdicts_checked);
						$display("  exp st=%0d n=%0d %h %h %h %h %h crc %h/%h",
							want.status, want.received_bytes, want.flow_value,
							want.battery_value, want.solar_value, want.peak_energy,
							want.offpeak_energy, want.received_crc, want.computed_crc);
						$display("  got st=%0d n=%0d %h %h %h %h %h crc %h/%h",
							res_data.status, res_data.received_bytes, res_data.flow_value,
							res_data.battery_value, res_data.solar_value,
							res_data.peak_energy, res_data.offpeak_energy,
							res_data.received_crc, res_data.computed_crc);
					end
				end
			end
		end
	end

	// Receiver stall: a new hold-off request restarts the count; otherwise stall
	// at random.
	always @(posedge clk) begin : stall_driver
		static int hold_seen_seq = 0;
		static int hold_left = 0;
		if (hold_off_seq != hold_seen_seq) begin
			hold_seen_seq = hold_off_seq;
			hold_left = hold_off_cycles;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Watchdog: end the run if it goes on far past any legal length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clear_frame_model();
		// Hold reset, then release it on an edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_verdict_cases();
		test_register_settings();
		test_input_backpressure();
		test_random_traffic(0, 0, 8'h00, 8'hFF, 7);
		test_random_traffic(50, 0, 8'hFF, 8'h00, 7);
		test_random_traffic(0, 50, 8'($urandom_range(255)), 8'($urandom_range(255)), 7);
		test_random_traffic(22, 22, 8'($urandom_range(255)), 8'($urandom_range(255)), 7);

		// Drain, then keep watching for any stray verdict to show up.
		while (pending_verdicts.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			fail_count++;
			$display("%0d verdicts never arrived", pending_verdicts.size());
		end

		$display("Covered %0d frames in %0d requests over four idle mixes and a hold-off.",
			frames_sent, items_sent);
		$display("Verdicts checked %0d: ok %0d, short %0d, bad header %0d, CRC %0d.",
			verdicts_checked, status_seen[ST_OK], status_seen[ST_SHORT],
			status_seen[ST_BAD], status_seen[ST_CRC]);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/mbrc_pkg.sv
rtl/mbrc_frame.sv
rtl/mbrc_outq.sv
rtl/modbus_response_checker.sv
dv/tb_modbus_response_checker.sv
